// ===== sv/i2c_master_bit_sequencer_macros.svh =====
// Assertion helpers used by the sequencer back end.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Check an implication or condition on every clock outside reset.
`define I2CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define I2CBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/i2cbs_pkg.sv =====
package i2cbs_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_W         = $clog2(BITS_PER_BYTE);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_BYTE - 1);

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [BITS_PER_BYTE-1:0] READ_BIT_MASK = BITS_PER_BYTE'(1);

  // Command codes
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_PROBE = 3'd4
  } mode_e;

  // Status codes on the final phase
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  // Line segments the back end runs, in bus order
  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_START,
    SEG_SEND,
    SEG_ACK,
    SEG_READ,
    SEG_RACK,
    SEG_STOP,
    SEG_BUSY
  } seg_e;

  typedef struct packed {
    logic [2:0]               mode;
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic                     start_first;
    logic                     stop_after;
    logic                     send_nack;
    logic                     start_sda_level;
    logic                     stop_sda_level;
    logic                     ack_sda_level;
    logic [BITS_PER_BYTE-1:0] read_levels;
    logic                     idle_scl_level;
    logic                     idle_sda_level;
  } in_t;

  typedef struct packed {
    logic                     scl_out;
    logic                     sda_out;
    logic [BITS_PER_BYTE-1:0] read_data;
    logic [1:0]               status;
    logic                     last_phase;
  } out_t;

  // Segments still to run for one command
  typedef struct packed {
    logic start;
    logic send;
    logic ack;
    logic read;
    logic stop;
    logic busy;
  } seg_flags_t;

  // Classified command passed from front to back
  typedef struct packed {
    seg_flags_t               flags;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     send_nack;
    logic [BITS_PER_BYTE-1:0] rx_data;
    logic [1:0]               status;
  } cmd_t;

  // Pick the earliest pending segment
  function automatic seg_e first_seg(input seg_flags_t f);
    seg_e s;
    if (f.start) begin
      s = SEG_START;
    end else if (f.send) begin
      s = SEG_SEND;
    end else if (f.ack) begin
      s = SEG_ACK;
    end else if (f.read) begin
      s = SEG_READ;
    end else if (f.stop) begin
      s = SEG_STOP;
    end else if (f.busy) begin
      s = SEG_BUSY;
    end else begin
      s = SEG_IDLE;
    end
    return s;
  endfunction

  // Clear the earliest pending segment
  function automatic seg_flags_t drop_first(input seg_flags_t f);
    seg_flags_t r;
    r = f;
    if (f.start) begin
      r.start = 1'b0;
    end else if (f.send) begin
      r.send = 1'b0;
    end else if (f.ack) begin
      r.ack = 1'b0;
    end else if (f.read) begin
      r.read = 1'b0;
    end else if (f.stop) begin
      r.stop = 1'b0;
    end else begin
      r.busy = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/i2cbs_front.sv =====
module i2cbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [i2cbs_pkg::BITS_PER_BYTE-1:0] cfg_wdata_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  i2cbs_pkg::in_t                  in_i,
  output logic                            cmd_push_o,
  output i2cbs_pkg::cmd_t                 cmd_o
);
  import i2cbs_pkg::*;

  logic [BITS_PER_BYTE-1:0] dev_addr_q;
  logic                     known;
  cmd_t                     cmd;

  // Hold the probe address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Classify the command into segments and its final status
  always_comb begin
    cmd   = '0;
    known = 1'b1;
    case (in_i.mode)
      MODE_START: begin
        cmd.flags.start = 1'b1;
        cmd.status      = in_i.start_sda_level ? ST_NACK : ST_OK;
      end
      MODE_STOP: begin
        cmd.flags.stop = 1'b1;
        cmd.status     = in_i.stop_sda_level ? ST_OK : ST_NACK;
      end
      MODE_WRITE: begin
        cmd.flags.start = in_i.start_first;
        if (in_i.start_first && in_i.start_sda_level) begin
          cmd.flags.stop = 1'b1;
          cmd.status     = ST_NACK;
        end else begin
          cmd.flags.send = 1'b1;
          cmd.flags.ack  = 1'b1;
          cmd.flags.stop = in_i.stop_after | in_i.ack_sda_level;
          cmd.tx_byte    = in_i.data_byte;
          cmd.status     = in_i.ack_sda_level ? ST_NACK : ST_OK;
        end
      end
      MODE_READ: begin
        cmd.flags.read = 1'b1;
        cmd.send_nack  = in_i.send_nack;
        cmd.rx_data    = in_i.read_levels;
        cmd.status     = ST_OK;
      end
      MODE_PROBE: begin
        if (in_i.idle_scl_level && in_i.idle_sda_level) begin
          cmd.flags.start = 1'b1;
          cmd.flags.send  = 1'b1;
          cmd.flags.ack   = 1'b1;
          cmd.tx_byte     = dev_addr_q | READ_BIT_MASK;
          cmd.status      = in_i.ack_sda_level ? ST_NACK : ST_OK;
        end else begin
          cmd.flags.busy = 1'b1;
          cmd.status     = ST_BUSY;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Drop unknown commands, forward the rest
  assign cmd_push_o = push_i && !full_i && known;
  assign cmd_o      = cmd;

endmodule

// ===== sv/i2cbs_cmd_fifo.sv =====
module i2cbs_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cbs_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output i2cbs_pkg::cmd_t rdata_o,
  output logic            empty_o
);
  import i2cbs_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/i2cbs_back.sv =====
`include "i2c_master_bit_sequencer_macros.svh"

module i2cbs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2cbs_pkg::cmd_t cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output i2cbs_pkg::out_t out_o,
  output logic            empty_o,
  input  logic            pop_i
);
  import i2cbs_pkg::*;

  seg_e                     seg_q, seg_d;
  seg_flags_t               flags_q, flags_d;
  logic [1:0]               step_q;
  logic [BIT_W-1:0]         bit_q;
  logic [BITS_PER_BYTE-1:0] sh_q;
  logic                     nack_q;
  logic [BITS_PER_BYTE-1:0] rx_q;
  logic [1:0]               status_q;
  logic                     scl_q, sda_q;
  logic                     out_valid_q;
  out_t                     out_q;

  logic ph_scl, ph_sda, seg_end;
  logic out_free, advance, done_seg, last_ph, load;
  seg_e pend_seg;

  assign out_free = !out_valid_q || pop_i;
  assign advance  = (seg_q != SEG_IDLE) && out_free;
  assign done_seg = advance && seg_end;
  assign pend_seg = first_seg(flags_q);
  assign last_ph  = seg_end && (seg_q != SEG_READ) && (pend_seg == SEG_IDLE);
  assign load     = ((seg_q == SEG_IDLE) || (done_seg && last_ph)) && !cmd_empty_i;
  assign cmd_pop_o = load;

  // Next segment
  always_comb begin
    seg_d   = seg_q;
    flags_d = flags_q;
    if (load) begin
      seg_d   = first_seg(cmd_i.flags);
      flags_d = drop_first(cmd_i.flags);
    end else if (done_seg) begin
      if (seg_q == SEG_READ) begin
        seg_d = SEG_RACK;
      end else begin
        seg_d   = pend_seg;
        flags_d = drop_first(flags_q);
      end
    end
  end

  // Line levels of the current phase
  always_comb begin
    ph_scl  = scl_q;
    ph_sda  = sda_q;
    seg_end = 1'b0;
    case (seg_q)
      SEG_START: begin
        case (step_q)
          2'd0:    ph_sda = 1'b1;
          2'd1:    ph_scl = 1'b1;
          2'd2:    ph_sda = 1'b0;
          default: begin
            ph_scl  = 1'b0;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_STOP: begin
        case (step_q)
          2'd0:    ph_sda = 1'b0;
          2'd1:    ph_scl = 1'b1;
          default: begin
            ph_sda  = 1'b1;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_SEND: begin
        case (step_q)
          2'd0:    ph_scl = 1'b0;
          2'd1:    ph_sda = sh_q[BITS_PER_BYTE-1];
          2'd2:    ph_scl = 1'b1;
          default: begin
            ph_scl  = 1'b0;
            seg_end = (bit_q == BIT_LAST);
          end
        endcase
      end
      SEG_ACK: begin
        case (step_q)
          2'd0:    ph_sda = 1'b1;
          2'd1:    ph_scl = 1'b1;
          default: begin
            ph_scl  = 1'b0;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_READ: begin
        case (step_q)
          2'd0:    ph_sda = 1'b1;
          2'd1:    ph_scl = 1'b0;
          2'd2:    ph_scl = 1'b1;
          default: begin
            ph_scl  = 1'b0;
            seg_end = (bit_q == BIT_LAST);
          end
        endcase
      end
      SEG_RACK: begin
        case (step_q)
          2'd0:    ph_sda = nack_q;
          2'd1:    ph_scl = 1'b1;
          default: begin
            ph_scl  = 1'b0;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_BUSY: begin
        seg_end = 1'b1;
      end
      default: begin
        seg_end = 1'b0;
      end
    endcase
  end

  // Segment state and line levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_IDLE;
      flags_q <= '0;
      step_q  <= '0;
      bit_q   <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      seg_q   <= seg_d;
      flags_q <= flags_d;
      if (advance) begin
        scl_q <= ph_scl;
        sda_q <= ph_sda;
        if (seg_end) begin
          step_q <= '0;
          bit_q  <= '0;
        end else if ((seg_q == SEG_SEND || seg_q == SEG_READ) && step_q == 2'd3) begin
          step_q <= (seg_q == SEG_SEND) ? 2'd1 : 2'd2;
          bit_q  <= bit_q + 1'b1;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  // Command payload and send shifter
  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q     <= cmd_i.tx_byte;
      nack_q   <= cmd_i.send_nack;
      rx_q     <= cmd_i.rx_data;
      status_q <= cmd_i.status;
    end else if (advance && seg_q == SEG_SEND && step_q == 2'd3) begin
      sh_q <= {sh_q[BITS_PER_BYTE-2:0], 1'b0};
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.scl_out    <= ph_scl;
      out_q.sda_out    <= ph_sda;
      out_q.read_data  <= last_ph ? rx_q : '0;
      out_q.status     <= last_ph ? status_q : ST_OK;
      out_q.last_phase <= last_ph;
    end
  end

  assign out_o   = out_q;
  assign empty_o = !out_valid_q;

  // Only one line changes per phase
  `I2CBS_ASSERT_NEVER(a_one_line, advance && (ph_scl != scl_q) && (ph_sda != sda_q), "both lines moved")
  // Intermediate phases carry no status
  `I2CBS_ASSERT(a_mid_status, out_valid_q && !out_q.last_phase |-> out_q.status == ST_OK, "status on mid phase")
  // Bit count only runs inside byte segments
  `I2CBS_ASSERT(a_bit_seg, bit_q != '0 |-> (seg_q == SEG_SEND || seg_q == SEG_READ), "stray bit count")

endmodule

// ===== sv/i2c_master_bit_sequencer.sv =====
// Channel | Handshake     | Payload       | Word
// command | push / full   | in_i  (in_t)  | one bus command
// phase   | pop  / empty  | out_o (out_t) | one line phase (SCL, SDA)
// config  | cfg_we_i      | cfg_wdata_i   | probe address byte
//
// One phase word per clock while pop keeps up; a command yields 1 to 35 phases.
// The sequencer takes the next queued command as it emits the last phase of the
// current one; from idle it first loads the command, then emits its first phase.
// The two-deep command queue holds up to two commands while the sequencer works.
// Reset drives both lines released high; unknown modes are taken and dropped.
module i2c_master_bit_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [i2cbs_pkg::BITS_PER_BYTE-1:0] cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  i2cbs_pkg::in_t                      in_i,
  output logic                                empty,
  input  logic                                pop,
  output i2cbs_pkg::out_t                     out_o
);
  import i2cbs_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_wdata, q_rdata;

  // Classify commands
  i2cbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .full_i     (q_full),
    .in_i       (in_i),
    .cmd_push_o (q_push),
    .cmd_o      (q_wdata)
  );

  // Decouple front and back
  i2cbs_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  // Drive line phases
  i2cbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_rdata),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .out_o      (out_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

  assign full = q_full;

endmodule
